// ===== rtl/rpe_pkg.sv =====
`timescale 1ns / 1ps

package rpe_pkg;

  // vector size; pair count is at least one
  localparam int unsigned VectorDim = 8;
  localparam int unsigned NumPairs  = ((VectorDim / 2) > 0) ? (VectorDim / 2) : 1;
  localparam int unsigned NumKCodes = 4;

  // fixed-point constants, Q32 unless noted
  localparam longint unsigned Log2TenKQ32  = 64'd57070290109;
  localparam longint unsigned Ln2Q32       = 64'd2977044472;
  localparam longint unsigned InvTwoPiQ32  = 64'd683565276;
  localparam int unsigned     ExpTerms     = 20;
  localparam int unsigned     CordicStages = 30;
  localparam logic signed [31:0] CordicGain = 32'sd652032874;  // Q30

  // phase step, cordic chain, product stage, output stage
  localparam int unsigned RpeLatency = CordicStages + 3;

  typedef struct packed {
    logic signed [15:0] x_even;
    logic signed [15:0] x_odd;
    logic        [1:0]  pair_index;
    logic        [15:0] position;
  } rpe_in_t;

  typedef struct packed {
    logic signed [15:0] out_even;
    logic signed [15:0] out_odd;
  } rpe_out_t;

  // data handed from one cordic cell to the next
  typedef struct packed {
    logic               valid;
    logic        [1:0]  quad;
    logic signed [15:0] xe;
    logic signed [15:0] xo;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } rpe_cell_t;

  // unsigned long division for the build-time tables
  function automatic longint unsigned div_u64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // phase increment per position for pair k, 2^32 is one turn
  function automatic logic [31:0] phase_step(input int unsigned k);
    longint unsigned e;
    longint unsigned x;
    longint unsigned term;
    longint unsigned v;
    longint unsigned rnd;
    longint          acc;
    int unsigned     ip;
    e    = div_u64(longint'(2 * k) * Log2TenKQ32, 64'(VectorDim));
    ip   = int'(e >> 32);
    x    = ((e & 64'hFFFF_FFFF) * Ln2Q32) >> 32;
    term = 64'd1 << 32;
    acc  = longint'(64'd1 << 32);
    for (longint unsigned n = 1; n <= ExpTerms; n++) begin
      term = div_u64((term * x) >> 32, n);
      if (n[0]) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    v   = (ip < 63) ? (longint'(acc) >> ip) : 64'd0;
    rnd = (v * InvTwoPiQ32 + (64'd1 << 31)) >> 32;
    return rnd[31:0];
  endfunction

  // pair index beyond the pair count uses the last pair
  function automatic logic [31:0] clamped_step(input int unsigned k);
    int unsigned kk;
    kk = (k >= NumPairs) ? (NumPairs - 1) : k;
    return phase_step(kk);
  endfunction

  localparam logic [31:0] StepTab [NumKCodes] = '{
    clamped_step(0), clamped_step(1), clamped_step(2), clamped_step(3)
  };

  // atan(2^-i) in turns, Q32
  function automatic logic signed [31:0] atan_turns(input int unsigned i);
    longint          acc;
    longint unsigned prod;
    longint unsigned term;
    longint unsigned r;
    bit              done;
    acc  = 0;
    done = 1'b0;
    if (i == 0) begin
      return 32'sd536870912;
    end
    for (int unsigned n = 0; n < 40; n++) begin
      if (!done) begin
        prod = longint'(i) * longint'(2 * n + 1);
        if (prod > 60) begin
          done = 1'b1;
        end else begin
          term = div_u64(64'd1 << (60 - prod), 64'(2 * n + 1));
          if (n[0]) begin
            acc = acc - longint'(term);
          end else begin
            acc = acc + longint'(term);
          end
        end
      end
    end
    r = ((longint'(acc) >> 28) * InvTwoPiQ32) >> 32;
    return signed'(r[31:0]);
  endfunction

endpackage

// ===== rtl/rpe_cordic_cell.sv =====
`timescale 1ns / 1ps

module rpe_cordic_cell #(
  parameter int unsigned Stage = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rpe_pkg::rpe_cell_t cell_i,
  output rpe_pkg::rpe_cell_t cell_o
);
  import rpe_pkg::*;

  localparam logic signed [31:0] Atan = atan_turns(Stage);

  logic signed [31:0] dx;
  logic signed [31:0] dy;
  rpe_cell_t          cell_d;
  rpe_cell_t          cell_q;

  // one micro-rotation, direction from the residual angle sign
  always_comb begin
    dx     = cell_i.y >>> Stage;
    dy     = cell_i.x >>> Stage;
    cell_d = cell_i;
    if (cell_i.z >= 0) begin
      cell_d.x = cell_i.x - dx;
      cell_d.y = cell_i.y + dy;
      cell_d.z = cell_i.z - Atan;
    end else begin
      cell_d.x = cell_i.x + dx;
      cell_d.y = cell_i.y - dy;
      cell_d.z = cell_i.z + Atan;
    end
  end

  // cell register, reset clears the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.valid <= 1'b0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== rtl/rpe_rotate.sv =====
`timescale 1ns / 1ps

module rpe_rotate (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rpe_pkg::rpe_cell_t cell_i,
  output logic               valid_o,
  output rpe_pkg::rpe_out_t  res_o
);
  import rpe_pkg::*;

  logic signed [31:0] cos_v;
  logic signed [31:0] sin_v;
  logic signed [47:0] p_ec_q;
  logic signed [47:0] p_os_q;
  logic signed [47:0] p_es_q;
  logic signed [47:0] p_oc_q;
  logic               valid_a_q;
  logic signed [48:0] sum_e;
  logic signed [48:0] sum_o;
  logic signed [48:0] sh_e;
  logic signed [48:0] sh_o;
  rpe_out_t           res_d;
  rpe_out_t           res_q;
  logic               valid_q;

  function automatic logic signed [15:0] sat16(input logic signed [48:0] v);
    if (v > 49'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -49'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // quadrant fold of the cordic result
  always_comb begin
    case (cell_i.quad)
      2'd0: begin
        cos_v = cell_i.x;
        sin_v = cell_i.y;
      end
      2'd1: begin
        cos_v = -cell_i.y;
        sin_v = cell_i.x;
      end
      2'd2: begin
        cos_v = -cell_i.x;
        sin_v = -cell_i.y;
      end
      default: begin
        cos_v = cell_i.y;
        sin_v = -cell_i.x;
      end
    endcase
  end

  // product stage
  always_ff @(posedge clk_i) begin
    p_ec_q <= cell_i.xe * cos_v;
    p_os_q <= cell_i.xo * sin_v;
    p_es_q <= cell_i.xe * sin_v;
    p_oc_q <= cell_i.xo * cos_v;
  end

  // sum, round to Q4.12, saturate
  always_comb begin
    sum_e          = 49'(p_ec_q) - 49'(p_os_q) + (49'sd1 <<< 29);
    sum_o          = 49'(p_es_q) + 49'(p_oc_q) + (49'sd1 <<< 29);
    sh_e           = sum_e >>> 30;
    sh_o           = sum_o >>> 30;
    res_d.out_even = sat16(sh_e);
    res_d.out_odd  = sat16(sh_o);
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // valid bits of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      valid_a_q <= cell_i.valid;
      valid_q   <= valid_a_q;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/rotary_position_embedding_unit.sv =====
`timescale 1ns / 1ps

// channel  | ports                     | handshake
// ---------+---------------------------+-----------------------------------
// item in  | start, in_i (rpe_in_t)    | taken when start high, busy low
// item out | valid_o, res_o (rpe_out_t)| one-cycle strobe, cannot be held
//
// A new item is taken every cycle; busy stays low.
// Each item passes through the phase multiply register, 30 cordic cells,
// one product and one output stage before its result appears.
// Reset clears only the valid bits along the chain.
// The results are not stalled; items flow through the fixed pipeline.
module rotary_position_embedding_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  rpe_pkg::rpe_in_t in_i,
  output logic             busy,
  output logic             valid_o,
  output rpe_pkg::rpe_out_t res_o
);
  import rpe_pkg::*;

  logic              accept;
  logic [47:0]       phase_prod;
  logic [31:0]       phase;
  rpe_cell_t         head_d;
  rpe_cell_t         head_q;
  rpe_cell_t         chain [CordicStages + 1];

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // phase = position times the pair's step, wrapped to 32 bits
  always_comb begin
    phase_prod   = in_i.position * StepTab[in_i.pair_index];
    phase        = phase_prod[31:0];
    head_d.valid = accept;
    head_d.quad  = phase[31:30];
    head_d.xe    = in_i.x_even;
    head_d.xo    = in_i.x_odd;
    head_d.x     = CordicGain;
    head_d.y     = '0;
    head_d.z     = {2'b00, phase[29:0]};
  end

  // head register, reset clears the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q.valid <= 1'b0;
    end else begin
      head_q <= head_d;
    end
  end

  assign chain[0] = head_q;

  // cordic cell chain
  for (genvar g = 0; g < CordicStages; g++) begin : g_cell
    rpe_cordic_cell #(
      .Stage(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cell_i(chain[g]),
      .cell_o(chain[g + 1])
    );
  end

  // rotate the pair by the cosine and sine
  rpe_rotate u_rotate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cell_i (chain[CordicStages]),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

endmodule

// ===== rtl/rpe_checker.sv =====
`timescale 1ns / 1ps

module rpe_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input rpe_pkg::rpe_in_t  in_i,
  input logic              busy,
  input logic              valid_o,
  input rpe_pkg::rpe_out_t res_o
);
  import rpe_pkg::*;

  logic [5:0] warm_q;
  logic       warm;
  logic       taken;

  assign taken = start && !busy;
  assign warm  = (warm_q == 6'(RpeLatency));

  // cycles since reset, saturating at the pipeline depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
    end else if (!warm) begin
      warm_q <= warm_q + 6'd1;
    end
  end

  // every taken item gives one result after the fixed latency
  a_item_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken |-> ##RpeLatency valid_o)
    else $error("result strobe missing after item was taken");

  // no result without an item taken the same latency before
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && warm) |-> $past(taken, RpeLatency))
    else $error("result strobe without a matching item");

  // a zero pair stays zero whatever the angle
  a_zero_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (taken && in_i.x_even == 16'sd0 && in_i.x_odd == 16'sd0)
      |-> ##RpeLatency (res_o.out_even == 16'sd0 && res_o.out_odd == 16'sd0))
    else $error("zero pair rotated to a nonzero result");

endmodule

bind rotary_position_embedding_unit rpe_checker u_chk (.*);

// ===== dv/tb_rotary_position_embedding_unit.sv =====
`timescale 1ns / 1ps

module tb_rotary_position_embedding_unit;
  import rpe_pkg::*;

  // fixed-point constants of the rotation, Q32 unless noted
  localparam longint unsigned Log2TenKQ32 = 64'd57070290109;
  localparam longint unsigned Ln2Q32      = 64'd2977044472;
  localparam longint unsigned InvTwoPiQ32 = 64'd683565276;
  localparam longint          GainQ30     = 64'sd652032874;
  localparam longint          HalfQ30     = 64'sd536870912;
  localparam int unsigned     NumStages   = 30;
  localparam int unsigned     NumTerms    = 20;
  localparam int unsigned     PairCount   = ((VectorDim / 2) > 0) ? (VectorDim / 2) : 1;

  localparam int unsigned NumRandom  = 1200;
  localparam int unsigned IdleLimit  = 1000;
  localparam int unsigned TailCycles = RpeLatency + 8;

  typedef struct {
    rpe_in_t pair;
    bit      drain;
  } pair_req_t;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  rpe_in_t  in_i;
  logic     busy;
  logic     valid_o;
  rpe_out_t res_o;

  pair_req_t   pair_q[$];
  rpe_out_t    rotated_q[$];
  logic [31:0] step_tab [4];
  longint      angle_tab [NumStages];

  int unsigned sent_cnt;
  int unsigned recv_cnt;
  int unsigned err_cnt;
  int unsigned gap_left;
  int unsigned burst_left;
  bit          burst_on;
  int unsigned idle_cycles;
  rpe_out_t    want;

  rotary_position_embedding_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .in_i   (in_i),
    .busy   (busy),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_error(input string msg);
    $display("ERROR: %s", msg);
    err_cnt++;
  endtask

  // phase advance per position for pair k, one turn is 2^32
  function automatic logic [31:0] freq_step(input int unsigned k);
    longint unsigned expo;
    longint unsigned frac;
    longint unsigned term;
    longint unsigned mag;
    longint unsigned rnd;
    longint          sum;
    int unsigned     whole;
    expo  = (longint'(2 * k) * Log2TenKQ32) / longint'(VectorDim);
    whole = expo[63:32];
    frac  = ((expo & 64'hFFFF_FFFF) * Ln2Q32) >> 32;
    term  = 64'd1 << 32;
    sum   = 64'sd1 <<< 32;
    // 2^-frac as an alternating exp series
    for (longint unsigned n = 1; n <= NumTerms; n++) begin
      term = ((term * frac) >> 32) / n;
      if (n[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    mag = (whole < 63) ? ($unsigned(sum) >> whole) : 64'd0;
    rnd = (mag * InvTwoPiQ32 + (64'd1 << 31)) >> 32;
    return rnd[31:0];
  endfunction

  // arctan(2^-i) in turns, Q32, from the arctan power series
  function automatic longint arc_turns(input int unsigned i);
    longint          acc;
    longint unsigned n;
    longint unsigned den;
    longint unsigned term;
    longint unsigned scaled;
    acc = 0;
    n   = 0;
    if (i == 0) begin
      return 64'sd536870912;
    end
    while (n < 40 && longint'(i) * (2 * n + 1) <= 60) begin
      den  = 2 * n + 1;
      term = (64'd1 << (60 - longint'(i) * den)) / den;
      if (n[0]) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
      n++;
    end
    scaled = (($unsigned(acc) >> 28) * InvTwoPiQ32) >> 32;
    return $signed(scaled);
  endfunction

  function automatic logic [15:0] clip_q12(input longint v);
    if (v > 32767) begin
      return 16'h7FFF;
    end
    if (v < -32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  // expected rotated pair for one item
  function automatic rpe_out_t rotate_pair(input rpe_in_t it);
    int unsigned     k;
    longint unsigned pos64;
    longint unsigned step64;
    longint unsigned wide;
    logic [31:0]     phase;
    longint          cx;
    longint          cy;
    longint          z;
    longint          dx;
    longint          dy;
    longint          c;
    longint          s;
    longint          xe;
    longint          xo;
    rpe_out_t        r;
    k = it.pair_index;
    if (k >= PairCount) begin
      k = PairCount - 1;
    end
    pos64  = it.position;
    step64 = step_tab[k];
    wide   = pos64 * step64;
    phase  = wide[31:0];
    cx = GainQ30;
    cy = 0;
    z  = phase[29:0];
    // rotation mode, driving the residual angle toward zero within the quadrant
    for (int unsigned i = 0; i < NumStages; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx = cx - dx;
        cy = cy + dy;
        z  = z - angle_tab[i];
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        z  = z + angle_tab[i];
      end
    end
    // quadrant fold
    case (phase[31:30])
      2'd0: begin
        c = cx;
        s = cy;
      end
      2'd1: begin
        c = -cy;
        s = cx;
      end
      2'd2: begin
        c = -cx;
        s = -cy;
      end
      default: begin
        c = cy;
        s = -cx;
      end
    endcase
    xe = {{48{it.x_even[15]}}, it.x_even};
    xo = {{48{it.x_odd[15]}}, it.x_odd};
    r.out_even = clip_q12((xe * c - xo * s + HalfQ30) >>> 30);
    r.out_odd  = clip_q12((xe * s + xo * c + HalfQ30) >>> 30);
    return r;
  endfunction

  task automatic queue_pair(input logic [15:0] xe, input logic [15:0] xo,
                            input logic [1:0] k, input logic [15:0] pos,
                            input bit drain);
    pair_req_t req;
    req.pair.x_even     = xe;
    req.pair.x_odd      = xo;
    req.pair.pair_index = k;
    req.pair.position   = pos;
    req.drain           = drain;
    pair_q.push_back(req);
  endtask

  // sample value: extremes, near unity, or anything
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      1, 2, 3: return 16'($urandom_range(0, 8192) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  // driver: one item per handshake, random gaps and idle-free bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        rotated_q.push_back(rotate_pair(in_i));
        sent_cnt++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pair_q.size() > 0 && !(pair_q[0].drain && sent_cnt != recv_cnt)) begin
          in_i  <= pair_q[0].pair;
          start <= 1'b1;
          void'(pair_q.pop_front());
          if (burst_left == 0) begin
            burst_on   = ($urandom_range(0, 2) == 0);
            burst_left = $urandom_range(10, 60);
          end else begin
            burst_left--;
          end
          gap_left = burst_on ? 0 : $urandom_range(0, 8);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobe is checked against the oldest expected pair
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      recv_cnt <= recv_cnt + 1;
      if (rotated_q.size() == 0) begin
        report_error($sformatf("unexpected result %0d: even %0d odd %0d", recv_cnt,
                               $signed(res_o.out_even), $signed(res_o.out_odd)));
      end else begin
        want = rotated_q.pop_front();
        if (res_o.out_even !== want.out_even) begin
          report_error($sformatf("result %0d out_even: got %0d want %0d", recv_cnt,
                                 $signed(res_o.out_even), $signed(want.out_even)));
        end
        if (res_o.out_odd !== want.out_odd) begin
          report_error($sformatf("result %0d out_odd: got %0d want %0d", recv_cnt,
                                 $signed(res_o.out_odd), $signed(want.out_odd)));
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || valid_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [15:0] pos;
    start       = 1'b0;
    in_i        = '0;
    rst_ni      = 1'b0;
    sent_cnt    = 0;
    recv_cnt    = 0;
    err_cnt     = 0;
    gap_left    = 0;
    burst_left  = 0;
    burst_on    = 1'b0;
    idle_cycles = 0;
    for (int unsigned k = 0; k < 4; k++) begin
      step_tab[k] = freq_step(k);
    end
    for (int unsigned i = 0; i < NumStages; i++) begin
      angle_tab[i] = arc_turns(i);
    end

    // directed: zero angle, full-scale samples, saturation both ways
    queue_pair(16'h0000, 16'h0000, 2'd0, 16'd0, 1'b0);
    queue_pair(16'h7FFF, 16'h0000, 2'd0, 16'd0, 1'b0);
    queue_pair(16'h8000, 16'h0000, 2'd1, 16'd0, 1'b0);
    queue_pair(16'h7FFF, 16'h8000, 2'd0, 16'd1, 1'b0);
    queue_pair(16'h8000, 16'h7FFF, 2'd0, 16'd1, 1'b0);
    queue_pair(16'h7FFF, 16'h7FFF, 2'd3, 16'hFFFF, 1'b0);
    queue_pair(16'h8000, 16'h8000, 2'd2, 16'hFFFF, 1'b0);
    queue_pair(16'h1000, 16'h0000, 2'd0, 16'd1, 1'b0);
    queue_pair(16'h0000, 16'h1000, 2'd1, 16'd1234, 1'b0);
    queue_pair(16'h1000, 16'hF000, 2'd2, 16'd300, 1'b0);
    queue_pair(16'hFFFF, 16'hFFFF, 2'd3, 16'd1, 1'b0);
    queue_pair(16'h0001, 16'h0001, 2'd3, 16'h8000, 1'b0);
    // walk through all four quadrants on the fastest pair
    for (int unsigned p = 2; p <= 7; p++) begin
      queue_pair(16'h1000, 16'h1000, 2'd0, 16'(p), 1'b0);
    end
    for (int unsigned k = 0; k < 4; k++) begin
      queue_pair(16'h7FFF, 16'h8000, 2'(k), 16'h7FFF, 1'b0);
    end

    // random pairs, with a drained pipeline now and then
    for (int unsigned n = 0; n < NumRandom; n++) begin
      case ($urandom_range(0, 7))
        0: pos = 16'($urandom_range(0, 1) ? 16'hFFFF : 16'h8000);
        1, 2: pos = 16'($urandom_range(0, 15));
        default: pos = 16'($urandom);
      endcase
      queue_pair(pick_sample(), pick_sample(), 2'($urandom_range(0, 3)), pos,
                 (n % 150) == 0);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pair_q.size() > 0 || start) @(posedge clk_i);
    while (recv_cnt != sent_cnt) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (rotated_q.size() != 0) begin
      report_error($sformatf("%0d expected results never arrived", rotated_q.size()));
    end
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rpe_pkg.sv
rtl/rpe_cordic_cell.sv
rtl/rpe_rotate.sv
rtl/rotary_position_embedding_unit.sv
rtl/rpe_checker.sv
dv/tb_rotary_position_embedding_unit.sv
